@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/etfi_pkg.sv @@
// types and constants of the escape-time fractal iterator
// no dependencies
package etfi_pkg;

	typedef struct packed {
		logic signed [31:0] point_re;
		logic signed [31:0] point_im;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] iteration_count;
		logic        escaped;
	} out_beat_t;

	typedef struct packed {
		logic [15:0]        iter_limit;
		logic [62:0]        escape_limit_sq;
		logic [3:0]         exponent;
		logic               julia_mode;
		logic signed [31:0] julia_c_re;
		logic signed [31:0] julia_c_im;
	} cfg_regs_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT_SQ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_RE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_JULIA_C_IM      = 3'd5;

	localparam logic [15:0] ITER_LIMIT_RST      = 16'd256;
	localparam logic [62:0] ESCAPE_LIMIT_SQ_RST = 63'h0400_0000_0000_0000;
	localparam logic [3:0]  EXPONENT_RST        = 4'd2;

endpackage

@@ src/etfi_mult.sv @@
// shared signed multiplier with registered product
// depends on nothing
module etfi_mult #(
	parameter int WIDTH = 32
) (
	input  logic                      clk,
	input  logic signed [WIDTH-1:0]   a,
	input  logic signed [WIDTH-1:0]   b,
	output logic signed [2*WIDTH-1:0] p
);

	logic signed [2*WIDTH-1:0] p_s1;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

	assign p = p_s1;

endmodule

@@ src/etfi_core.sv @@
// iteration sequencer: complex power, add of c, magnitude check
// depends on etfi_pkg and etfi_mult
module etfi_core import etfi_pkg::*; #(
	parameter int DATA_WIDTH   = 32,
	parameter int FRAC_BITS    = 28,
	parameter int MAX_EXPONENT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  cfg_regs_t cfg,
	input  in_beat_t  point,
	output logic      done,
	output out_beat_t result
);

	localparam int DW = DATA_WIDTH;
	localparam int PW = 2 * DW;
	localparam int FW = PW - FRAC_BITS;
	localparam int AW = FW + 1;
	localparam int EW = $clog2(MAX_EXPONENT + 1);
	localparam longint VMAX_L = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam logic signed [31:0] VMAX32 = 32'(VMAX_L);
	localparam logic signed [31:0] VMIN32 = 32'(-VMAX_L - 64'sd1);

	localparam logic [2:0] PH0 = 3'd0;
	localparam logic [2:0] PH1 = 3'd1;
	localparam logic [2:0] PH2 = 3'd2;
	localparam logic [2:0] PH3 = 3'd3;
	localparam logic [2:0] PH4 = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADDC,
		S_MAG,
		S_CMP
	} state_t;

	function automatic logic signed [DW-1:0] sat(input logic signed [31:0] v);
		logic signed [DW-1:0] r;
		if (v > VMAX32) r = VMAX32[DW-1:0];
		else if (v < VMIN32) r = VMIN32[DW-1:0];
		else r = v[DW-1:0];
		return r;
	endfunction

	function automatic logic fits(input logic signed [AW-1:0] v);
		return v[AW-1:DW-1] == {(AW-DW+1){v[AW-1]}};
	endfunction

	state_t               state_q;
	logic [2:0]           ph_q;
	logic                 first_q;
	logic [15:0]          iter_q;
	logic [EW-1:0]        e_q;
	logic [EW-1:0]        mleft_q;
	logic signed [DW-1:0] zr_q, zi_q, wr_q, wi_q, cr_q, ci_q;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic [PW-1:0]        mag_q;
	logic                 done_q;
	out_beat_t            res_q;

	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] fl, new_im;
	logic signed [DW:0]   sr, si;
	logic                 add_ovf;
	logic                 more_iter;
	logic                 bound_ok;
	logic [EW-1:0]        e_eff;
	logic signed [DW-1:0] pr_sat, pi_sat;
	out_beat_t            ovf_res;

	etfi_mult #(.WIDTH(DW)) u_mult (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = zr_q;
		mul_b = zr_q;
		case (state_q)
			S_MUL: begin
				case (ph_q[1:0])
					2'd0: begin mul_a = wr_q; mul_b = zr_q; end
					2'd1: begin mul_a = wi_q; mul_b = zi_q; end
					2'd2: begin mul_a = wr_q; mul_b = zi_q; end
					default: begin mul_a = wi_q; mul_b = zr_q; end
				endcase
			end
			S_MAG: begin
				if (ph_q == PH0) begin
					mul_a = zr_q;
					mul_b = zr_q;
				end else begin
					mul_a = zi_q;
					mul_b = zi_q;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (int'(cfg.exponent) < 2) e_eff = EW'(2);
		else if (int'(cfg.exponent) > MAX_EXPONENT) e_eff = EW'(MAX_EXPONENT);
		else e_eff = EW'(cfg.exponent);
	end

	assign fl        = {prod[PW-1], prod[PW-1:FRAC_BITS]};
	assign new_im    = acc_im_q + fl;
	assign sr        = {wr_q[DW-1], wr_q} + {cr_q[DW-1], cr_q};
	assign si        = {wi_q[DW-1], wi_q} + {ci_q[DW-1], ci_q};
	assign add_ovf   = (sr[DW] != sr[DW-1]) || (si[DW] != si[DW-1]);
	assign more_iter = (17'(iter_q) + 17'd1) < 17'(cfg.iter_limit);
	assign bound_ok  = cfg.iter_limit >= 16'd2;
	assign pr_sat    = sat(point.point_re);
	assign pi_sat    = sat(point.point_im);

	// overflow in the first map lands on index 1 when the loop runs at all
	always_comb begin
		if (first_q) begin
			ovf_res.iteration_count = bound_ok ? 16'd1 : 16'd0;
			ovf_res.escaped         = bound_ok;
		end else begin
			ovf_res.iteration_count = iter_q;
			ovf_res.escaped         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH0;
			first_q  <= 1'b0;
			iter_q   <= '0;
			e_q      <= '0;
			mleft_q  <= '0;
			zr_q     <= '0;
			zi_q     <= '0;
			wr_q     <= '0;
			wi_q     <= '0;
			cr_q     <= '0;
			ci_q     <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
			mag_q    <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						if (cfg.julia_mode) begin
							zr_q <= pr_sat;
							zi_q <= pi_sat;
							wr_q <= pr_sat;
							wi_q <= pi_sat;
							cr_q <= sat(cfg.julia_c_re);
							ci_q <= sat(cfg.julia_c_im);
						end else begin
							zr_q <= '0;
							zi_q <= '0;
							wr_q <= '0;
							wi_q <= '0;
							cr_q <= pr_sat;
							ci_q <= pi_sat;
						end
						first_q <= 1'b1;
						iter_q  <= '0;
						e_q     <= e_eff;
						mleft_q <= e_eff - EW'(1);
						ph_q    <= PH0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						PH1: acc_re_q <= fl;
						PH2: acc_re_q <= acc_re_q - fl;
						PH3: acc_im_q <= fl;
						PH4: begin
							if (!fits(acc_re_q) || !fits(new_im)) begin
								res_q   <= ovf_res;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								wr_q <= acc_re_q[DW-1:0];
								wi_q <= new_im[DW-1:0];
								ph_q <= PH0;
								if (mleft_q == EW'(1)) begin
									state_q <= S_ADDC;
								end else begin
									mleft_q <= mleft_q - EW'(1);
								end
							end
						end
						default: ;
					endcase
				end
				S_ADDC: begin
					ph_q <= PH0;
					if (add_ovf) begin
						res_q   <= ovf_res;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						zr_q <= sr[DW-1:0];
						zi_q <= si[DW-1:0];
						wr_q <= sr[DW-1:0];
						wi_q <= si[DW-1:0];
						if (first_q) begin
							first_q <= 1'b0;
							iter_q  <= 16'd1;
							if (bound_ok) begin
								mleft_q <= e_q - EW'(1);
								state_q <= S_MUL;
							end else begin
								res_q   <= '0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_MAG;
						end
					end
				end
				S_MAG: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						PH1: mag_q <= prod;
						PH2: begin
							mag_q   <= mag_q + prod;
							state_q <= S_CMP;
						end
						default: ;
					endcase
				end
				S_CMP: begin
					ph_q <= PH0;
					if (64'(mag_q) > 64'(cfg.escape_limit_sq)) begin
						res_q.iteration_count <= iter_q;
						res_q.escaped         <= 1'b1;
						done_q                <= 1'b1;
						state_q               <= S_IDLE;
					end else if (more_iter) begin
						iter_q  <= iter_q + 16'd1;
						mleft_q <= e_q - EW'(1);
						state_q <= S_MUL;
					end else begin
						res_q   <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ src/escape_time_fractal_iterator.sv @@
// top level of the escape-time fractal iterator: config registers, handshake
// depends on etfi_pkg, etfi_core, assert_macros.svh
//
// channel   dir  handshake                    beat
// point     in   start && !busy               in_beat_t (point_re, point_im)
// result    out  result_valid, one cycle      out_beat_t (iteration_count, escaped)
// cfg       in   cfg_valid && cfg_ready       cfg_index, cfg_data
//
// one beat at a time; busy stays high from the accepted point until the result shows
// per point: e-1 complex multiplies and the add of c for the first map and for each
// loop index, each loop index also with a magnitude check, e being the clamped exponent;
// the single shared multiplier sets the pace, four products per complex multiply, two per magnitude
// the result strobe is high one cycle; the receiver cannot stall it
// reset loads the register defaults; no clearing pass, ready right after reset
`include "assert_macros.svh"

module escape_time_fractal_iterator import etfi_pkg::*; #(
	parameter int DATA_WIDTH   = 32,
	parameter int FRAC_BITS    = 28,
	parameter int MAX_EXPONENT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_beat_t              point,
	output logic                  result_valid,
	output out_beat_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t cfg_q;
	logic      busy_q;
	logic      go;
	logic      core_done;
	out_beat_t core_result;

	// registers must only change while idle, so the core reads them live; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iter_limit      <= ITER_LIMIT_RST;
			cfg_q.escape_limit_sq <= ESCAPE_LIMIT_SQ_RST;
			cfg_q.exponent        <= EXPONENT_RST;
			cfg_q.julia_mode      <= 1'b0;
			cfg_q.julia_c_re      <= '0;
			cfg_q.julia_c_im      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ITER_LIMIT:      cfg_q.iter_limit      <= cfg_data[15:0];
				CFG_ESCAPE_LIMIT_SQ: cfg_q.escape_limit_sq <= cfg_data[62:0];
				CFG_EXPONENT:        cfg_q.exponent        <= cfg_data[3:0];
				CFG_JULIA_MODE:      cfg_q.julia_mode      <= cfg_data[0];
				CFG_JULIA_C_RE:      cfg_q.julia_c_re      <= cfg_data[31:0];
				CFG_JULIA_C_IM:      cfg_q.julia_c_im      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// accept a point when idle; the core captures it on the same edge
	assign go = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
		end else if (core_done) begin
			busy_q <= 1'b0;
		end
	end

	etfi_core #(
		.DATA_WIDTH   (DATA_WIDTH),
		.FRAC_BITS    (FRAC_BITS),
		.MAX_EXPONENT (MAX_EXPONENT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cfg    (cfg_q),
		.point  (point),
		.done   (core_done),
		.result (core_result)
	);

	assign busy         = busy_q;
	assign result_valid = core_done;
	assign result       = core_result;

	// a result only comes out for a point in flight
	`ASSERT_IMPL(a_result_in_flight, clk, arst_n, result_valid, busy,
		"result without an accepted point")
	// an accepted point makes the block busy
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy,
		"not busy after accepting a point")
	// one result per point, so never two in a row
	`ASSERT_NEXT(a_single_strobe, clk, arst_n, result_valid, !result_valid,
		"result strobe held longer than one cycle")
	// no escape means the count reads zero
	`ASSERT_IMPL(a_zero_count, clk, arst_n, result_valid && !result.escaped,
		result.iteration_count == 16'd0, "nonzero count without escape")

endmodule
